// ----- rtl/core/ntw_pkg.sv -----
// ntw_pkg: shared widths, word codes and the group descriptor type for
// the number to word token block; no dependencies
package ntw_pkg;

	localparam int NUM_W   = 31;                 // input integer width
	localparam int WORD_W  = 5;                  // word code width
	localparam int DIGITS  = 10;                 // decimal digits of the largest input
	localparam int BCD_W   = 4 * DIGITS;
	localparam int CNT_W   = $clog2(NUM_W);      // conversion bit counter
	localparam int NGROUPS = 4;                  // units, thousand, million, billion
	localparam int GRP_IW  = $clog2(NGROUPS);

	// scale of a three digit group
	localparam logic [GRP_IW-1:0] SCALE_NONE     = 2'd0;
	localparam logic [GRP_IW-1:0] SCALE_THOUSAND = 2'd1;
	localparam logic [GRP_IW-1:0] SCALE_MILLION  = 2'd2;
	localparam logic [GRP_IW-1:0] SCALE_BILLION  = 2'd3;

	// word codes
	localparam logic [WORD_W-1:0] WORD_TEN_BASE  = 5'd9;   // Ten, teens are this plus ones
	localparam logic [WORD_W-1:0] WORD_TENS_BASE = 5'd17;  // Twenty is this plus two
	localparam logic [WORD_W-1:0] WORD_HUNDRED   = 5'd27;
	localparam logic [WORD_W-1:0] WORD_BILLION   = 5'd30;

	// one non-zero three digit group, as handed from front to back
	typedef struct packed {
		logic [3:0]        hund;
		logic [3:0]        tens;
		logic [3:0]        ones;
		logic [GRP_IW-1:0] scale;
		logic              last;   // no non-zero group follows
	} grp_t;

endpackage

// ----- rtl/core/ntw_num_if.sv -----
// ntw_num_if: input channel carrying one integer per transaction
// depends on ntw_pkg
interface ntw_num_if import ntw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [NUM_W-1:0] number_value;

	modport source (output valid, output number_value, input ready);
	modport sink   (input valid, input number_value, output ready);
endinterface

// ----- rtl/core/ntw_word_if.sv -----
// ntw_word_if: output channel carrying one word token per transaction
// depends on ntw_pkg
interface ntw_word_if import ntw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word_code;
	logic              last_word;

	modport source (output valid, output word_code, output last_word, input ready);
	modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

// ----- rtl/core/ntw_front.sv -----
// ntw_front: accepts an integer, converts it to decimal one bit per cycle
// and issues its non-zero three digit groups; depends on ntw_pkg, ntw_num_if
module ntw_front import ntw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	ntw_num_if.sink  num,
	output grp_t     grp,
	output logic     grp_push,
	input  logic     grp_full
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(NUM_W - 1);

	logic [1:0]        state_q;
	logic [NUM_W-1:0]  sh_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [GRP_IW-1:0] g_q;

	logic [BCD_W-1:0]   adj;
	logic [3:0]         gh [NGROUPS];
	logic [3:0]         gt [NGROUPS];
	logic [3:0]         go [NGROUPS];
	logic [NGROUPS-1:0] gz;
	logic [NGROUPS-1:0] lower_zero;
	logic               step;

	assign num.ready = (state_q == ST_IDLE);

	// add-3 correction on each digit before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// digits of each group; the billions group holds a single digit
	always_comb begin
		for (int g = 0; g < NGROUPS - 1; g++) begin
			gh[g] = bcd_q[g*12 + 8 +: 4];
			gt[g] = bcd_q[g*12 + 4 +: 4];
			go[g] = bcd_q[g*12 +: 4];
		end
		gh[NGROUPS-1] = 4'd0;
		gt[NGROUPS-1] = 4'd0;
		go[NGROUPS-1] = bcd_q[BCD_W-1 -: 4];
		for (int g = 0; g < NGROUPS; g++) begin
			gz[g] = (gh[g] == 4'd0) && (gt[g] == 4'd0) && (go[g] == 4'd0);
		end
		lower_zero[0] = 1'b1;
		for (int g = 1; g < NGROUPS; g++) begin
			lower_zero[g] = lower_zero[g-1] && gz[g-1];
		end
	end

	assign grp.hund  = gh[g_q];
	assign grp.tens  = gt[g_q];
	assign grp.ones  = go[g_q];
	assign grp.scale = g_q;
	assign grp.last  = lower_zero[g_q];

	assign grp_push = (state_q == ST_PUSH) && !gz[g_q] && !grp_full;
	assign step     = gz[g_q] || !grp_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			g_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (num.valid) begin
						state_q <= ST_CONV;
						cnt_q   <= '0;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_BIT) begin
						state_q <= ST_PUSH;
						g_q     <= SCALE_BILLION;
					end
				end
				ST_PUSH: begin
					if (step) begin
						if (g_q == SCALE_NONE) begin
							state_q <= ST_IDLE;
						end else begin
							g_q <= g_q - 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// conversion datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && num.valid) begin
			sh_q  <= num.number_value;
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			bcd_q <= {adj[BCD_W-2:0], sh_q[NUM_W-1]};
			sh_q  <= {sh_q[NUM_W-2:0], 1'b0};
		end
	end

endmodule

// ----- rtl/core/ntw_queue.sv -----
// ntw_queue: small register queue of group descriptors between front and back
// depends on ntw_pkg
module ntw_queue import ntw_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  grp_t wr_data,
	input  logic push,
	output logic full,
	output grp_t rd_data,
	input  logic pop,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	grp_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT) else $error("queue count out of range");

endmodule

// ----- rtl/core/ntw_back.sv -----
// ntw_back: expands one group descriptor into its word tokens and drives
// the output register; depends on ntw_pkg, ntw_word_if
module ntw_back import ntw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  grp_t       grp,
	input  logic       grp_empty,
	output logic       grp_pop,
	ntw_word_if.source word
);

	// word slots of a group, in reading order
	localparam int SL_HUND  = 0;
	localparam int SL_HWORD = 1;
	localparam int SL_TENS  = 2;
	localparam int SL_ONES  = 3;
	localparam int SL_SCALE = 4;
	localparam int NSLOT    = 5;

	grp_t              ent_q;
	logic [NSLOT-1:0]  en_q;
	logic              valid_q;
	logic [WORD_W-1:0] code_q;
	logic              last_q;

	logic [NSLOT-1:0]  en_new;
	logic [NSLOT-1:0]  lowest;
	logic [WORD_W-1:0] slot_code [NSLOT];
	logic [WORD_W-1:0] code_sel;
	logic              adv;

	always_comb begin
		en_new[SL_HUND]  = (grp.hund != 4'd0);
		en_new[SL_HWORD] = (grp.hund != 4'd0);
		en_new[SL_TENS]  = (grp.tens != 4'd0);
		en_new[SL_ONES]  = (grp.ones != 4'd0) && (grp.tens != 4'd1);
		en_new[SL_SCALE] = (grp.scale != SCALE_NONE);
	end

	always_comb begin
		slot_code[SL_HUND]  = {1'b0, ent_q.hund} - 5'd1;
		slot_code[SL_HWORD] = WORD_HUNDRED;
		if (ent_q.tens == 4'd1) begin
			slot_code[SL_TENS] = WORD_TEN_BASE + {1'b0, ent_q.ones};
		end else begin
			slot_code[SL_TENS] = WORD_TENS_BASE + {1'b0, ent_q.tens};
		end
		slot_code[SL_ONES]  = {1'b0, ent_q.ones} - 5'd1;
		slot_code[SL_SCALE] = WORD_HUNDRED + {3'b000, ent_q.scale};
	end

	assign lowest = en_q & (~en_q + 1'b1);

	always_comb begin
		code_sel = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (lowest[i]) begin
				code_sel = slot_code[i];
			end
		end
	end

	assign adv     = (en_q != '0) && (!valid_q || word.ready);
	assign grp_pop = (en_q == '0) && !grp_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= '0;
			valid_q <= 1'b0;
		end else begin
			if (grp_pop) begin
				en_q <= en_new;
			end else if (adv) begin
				en_q <= en_q & ~lowest;
			end
			if (adv) begin
				valid_q <= 1'b1;
			end else if (word.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_pop) begin
			ent_q <= grp;
		end
		if (adv) begin
			code_q <= code_sel;
			last_q <= ent_q.last && ((en_q & ~lowest) == '0);
		end
	end

	assign word.valid     = valid_q;
	assign word.word_code = code_q;
	assign word.last_word = last_q;

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		word.valid |-> word.word_code <= WORD_BILLION) else $error("word code out of range");
	a_group_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		grp_pop |=> en_q != '0) else $error("group descriptor with no words");
	a_slot_retire: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> en_q == ($past(en_q) & ~$past(lowest)))
		else $error("word slot not retired after issue");

endmodule

// ----- rtl/core/number_to_word_tokens.sv -----
// number_to_word_tokens: top level, spells an integer as english word tokens
// depends on ntw_pkg, ntw_num_if, ntw_word_if, ntw_front, ntw_queue, ntw_back

// Takes one unsigned 31-bit integer per input transaction and returns, in
// reading order, the short scale english words that spell it, one word code
// per output transaction: 0-18 one..nineteen, 19-26 twenty..ninety,
// 27 hundred, 28 thousand, 29 million, 30 billion. The final word of a number
// has last_word set. Zero groups give no words, not even their scale word,
// and an input of zero gives no output transactions at all. Numbers are taken
// one at a time: the front accepts a number, converts it to decimal one bit
// per cycle, then issues its non-zero three digit groups, and accepts no new
// number until it is through with the last group. Groups wait in a small queue
// (QUEUE_DEPTH entries) for the back, which loads a group and then issues its
// words one at a time, at most 16 words per number. The word output is
// registered, so the block keeps converting the next number while words wait
// to be taken; a stalled output fills the queue and then holds the front once
// it has a group to issue. Nothing is kept between numbers and there is no
// configuration.

module number_to_word_tokens import ntw_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	ntw_num_if.sink    num,
	ntw_word_if.source word
);

	// group descriptors between front and back
	grp_t push_grp;
	grp_t pop_grp;
	logic push;
	logic full;
	logic pop;
	logic empty;

	// decimal conversion and group issue
	ntw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.num      (num),
		.grp      (push_grp),
		.grp_push (push),
		.grp_full (full)
	);

	// decouples conversion from word output
	ntw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (push_grp),
		.push    (push),
		.full    (full),
		.rd_data (pop_grp),
		.pop     (pop),
		.empty   (empty)
	);

	// word expansion and output register
	ntw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp       (pop_grp),
		.grp_empty (empty),
		.grp_pop   (pop),
		.word      (word)
	);

endmodule

// ----- test/tb_number_to_word_tokens.sv -----
// tb_number_to_word_tokens: self-checking testbench for number_to_word_tokens
// drives numbers, predicts the english word tokens and checks them in order
// depends on ntw_pkg, ntw_num_if, ntw_word_if and the number_to_word_tokens rtl
module tb_number_to_word_tokens;
	import ntw_pkg::*;

	// scale words and the first unit word that the package leaves out
	localparam logic [WORD_W-1:0] WORD_ONE      = 5'd0;
	localparam logic [WORD_W-1:0] WORD_THOUSAND = 5'd28;
	localparam logic [WORD_W-1:0] WORD_MILLION  = 5'd29;

	localparam logic [NUM_W-1:0] NUM_MAX = 31'd2147483647;

	// cycles with no transaction on either side before the run is called hung;
	// the long output hold and the conversion of a number both fit inside it
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int RX_HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES     = 200;   // quiet time after the last word
	localparam int PHASE_ITEMS     = 58;
	localparam int PRESSURE_ITEMS  = 20;

	typedef struct packed {
		logic [WORD_W-1:0] code;
		logic              last;
	} word_tok_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ntw_num_if  num_ch ();
	ntw_word_if word_ch ();

	number_to_word_tokens u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.word   (word_ch)
	);

	// 20 time unit period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [NUM_W-1:0]  number_pending_q [$];   // numbers waiting to be driven
	word_tok_t         word_exp_q [$];         // words still owed by the block
	logic [WORD_W-1:0] spelled_words [$];      // scratch for one number

	// flow control knobs, percent of cycles
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;

	// long receiver hold, requested by the stimulus and counted below
	int rx_hold_req  = 0;
	int rx_hold_ack  = 0;
	int rx_hold_left = 0;

	logic num_taken = 1'b0;   // input transaction at the last rising edge

	int mismatch_count   = 0;
	int numbers_in       = 0;
	int words_out        = 0;
	int silent_numbers   = 0;
	int longest_spelling = 0;
	int quiet_cycles     = 0;

	// extremes, teens, round tens, empty remainders and zero groups
	logic [NUM_W-1:0] directed_nums [25] = '{
		31'd0, 31'd1, 31'd9, 31'd10, 31'd11, 31'd13, 31'd19, 31'd20, 31'd21,
		31'd99, 31'd100, 31'd101, 31'd110, 31'd118, 31'd200, 31'd999,
		31'd1000, 31'd1001, 31'd12000, 31'd1000000, 31'd1000001,
		31'd100010000, 31'd1000000000, 31'd2000000000, 31'd2147483647
	};

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at word %0d: %s got %0d want %0d", words_out, what, got, want);
		mismatch_count++;
	endtask

	// words of one three digit group: hundreds, then a teen or tens and units
	function automatic void spell_group(input int unsigned grp);
		int unsigned hund;
		int unsigned rest;
		hund = grp / 100;
		rest = grp % 100;
		if (hund != 0) begin
			spelled_words.push_back(WORD_ONE + WORD_W'(hund - 1));
			spelled_words.push_back(WORD_HUNDRED);
		end
		if (rest >= 20) begin
			spelled_words.push_back(WORD_TENS_BASE + WORD_W'(rest / 10));
			rest = rest % 10;
		end
		if (rest != 0)
			spelled_words.push_back(WORD_ONE + WORD_W'(rest - 1));
	endfunction

	// expected token stream for one accepted number, appended to word_exp_q
	function automatic void spell_number(input logic [NUM_W-1:0] value);
		int unsigned n;
		int unsigned grp;
		int unsigned div;
		logic [WORD_W-1:0] scale_word;
		int s;
		n = 32'(value);
		spelled_words.delete();
		for (s = NGROUPS - 1; s >= 0; s--) begin
			case (s)
				SCALE_BILLION: begin
					div = 1000000000;
					scale_word = WORD_BILLION;
				end
				SCALE_MILLION: begin
					div = 1000000;
					scale_word = WORD_MILLION;
				end
				SCALE_THOUSAND: begin
					div = 1000;
					scale_word = WORD_THOUSAND;
				end
				default: begin
					div = 1;
					scale_word = WORD_ONE;
				end
			endcase
			grp = (n / div) % 1000;
			// zero group gives nothing, not even its scale word
			if (grp != 0) begin
				spell_group(grp);
				if (s != SCALE_NONE)
					spelled_words.push_back(scale_word);
			end
		end
		for (int i = 0; i < spelled_words.size(); i++)
			word_exp_q.push_back('{code: spelled_words[i], last: i == spelled_words.size() - 1});
		if (spelled_words.size() == 0)
			silent_numbers++;
		if (spelled_words.size() > longest_spelling)
			longest_spelling = spelled_words.size();
	endfunction

	// random number, mostly built from groups so that zero groups, empty
	// remainders and round values come up often
	function automatic logic [NUM_W-1:0] random_number();
		longint unsigned v;
		int unsigned grp;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 2) begin
			v = 64'($urandom() & 32'h7fff_ffff);
		end else if (mode < 4) begin
			v = 64'($urandom_range(0, 999));
		end else if (mode < 9) begin
			v = 64'($urandom_range(0, 2));
			repeat (3) begin
				case ($urandom_range(0, 5))
					0, 1:    grp = 0;
					2:       grp = 10 * $urandom_range(0, 99);
					default: grp = $urandom_range(1, 999);
				endcase
				v = v * 1000 + 64'(grp);
			end
			if (v > NUM_MAX)
				v = v - 1000000000;
		end else begin
			case ($urandom_range(0, 3))
				0:       v = 64'(NUM_MAX);
				1:       v = 64'(NUM_MAX) - 64'($urandom_range(0, 1000));
				2:       v = 64'd1000000000 * 64'($urandom_range(1, 2));
				default: v = 0;
			endcase
		end
		return NUM_W'(v);
	endfunction

	// sender: offers the queued numbers at falling edges, idling at random
	always @(negedge clk) begin
		if (arst_n) begin
			if (!num_ch.valid || num_taken) begin
				if (number_pending_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					num_ch.valid        <= 1'b1;
					num_ch.number_value <= number_pending_q.pop_front();
				end else begin
					num_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stalls at random, and not at all ready during a long hold
	always @(negedge clk) begin
		if (arst_n)
			word_ch.ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// long hold counter, armed once per request from the stimulus
	always @(negedge clk) begin
		if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end else if (rx_hold_req != rx_hold_ack) begin
			rx_hold_left <= RX_HOLD_CYCLES;
			rx_hold_ack  <= rx_hold_req;
		end
	end

	// monitor: predicts on each accepted number, checks each accepted word
	always @(posedge clk) begin : word_monitor
		word_tok_t want;
		logic any_transaction;
		num_taken <= num_ch.valid && num_ch.ready;
		if (arst_n) begin
			any_transaction = 1'b0;
			if (word_ch.valid && word_ch.ready) begin
				any_transaction = 1'b1;
				if (word_exp_q.size() == 0) begin
					report_mismatch("word with nothing owed, code", int'(word_ch.word_code), 0);
				end else begin
					want = word_exp_q.pop_front();
					if (word_ch.word_code !== want.code)
						report_mismatch("word_code", int'(word_ch.word_code), int'(want.code));
					if (word_ch.last_word !== want.last)
						report_mismatch("last_word", int'(word_ch.last_word), int'(want.last));
				end
				words_out++;
			end
			// the words of a number come long after it, so order here is free
			if (num_ch.valid && num_ch.ready) begin
				any_transaction = 1'b1;
				spell_number(num_ch.number_value);
				numbers_in++;
			end
			quiet_cycles = any_transaction ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("watchdog: no transaction for %0d cycles, %0d words owed",
					quiet_cycles, word_exp_q.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// waits until every queued number is taken and every owed word has come
	task automatic drain_all();
		while (number_pending_q.size() != 0 || num_ch.valid)
			@(posedge clk);
		while (word_exp_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int tx_pct, input int rx_pct, input int items);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (items)
			number_pending_q.push_back(random_number());
		drain_all();
	endtask

	initial begin
		num_ch.valid        = 1'b0;
		num_ch.number_value = '0;
		word_ch.ready       = 1'b0;
		arst_n              = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed numbers at full rate
		foreach (directed_nums[i])
			number_pending_q.push_back(directed_nums[i]);
		drain_all();

		// flow control phases: none, sender gaps, receiver stalls, both
		random_phase(0, 0, PHASE_ITEMS);
		random_phase(45, 0, PHASE_ITEMS);
		random_phase(0, 45, PHASE_ITEMS);
		random_phase(17, 17, PHASE_ITEMS);

		// output held off while numbers keep coming: the group queue fills
		// and the input side has to stall
		rx_hold_req++;
		random_phase(0, 0, PRESSURE_ITEMS);

		// anything showing up now has no number behind it
		repeat (TAIL_CYCLES) @(posedge clk);
		if (word_exp_q.size() != 0)
			report_mismatch("words never delivered, count", 0, word_exp_q.size());

		$display("covered %0d numbers (%0d with no words, up to %0d words each), %0d words",
			numbers_in, silent_numbers, longest_spelling, words_out);
		$display("flow control: full rate, sender gaps, receiver stalls, both, long output hold");
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/ntw_pkg.sv
rtl/core/ntw_num_if.sv
rtl/core/ntw_word_if.sv
rtl/core/ntw_front.sv
rtl/core/ntw_queue.sv
rtl/core/ntw_back.sv
rtl/core/number_to_word_tokens.sv
test/tb_number_to_word_tokens.sv
